// ----- rtl/clce_pkg.sv -----
`default_nettype none

package clce_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed widths of the channel fields
    localparam int STEP_W      = 16;
    localparam int VALUE_OUT_W = 32;
    localparam int POS_W       = 12;
    localparam int COUNT_OUT_W = 13;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_POP    = 2'd1,
        MODE_SHIFT  = 2'd2,
        MODE_SEEK   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_status;

endpackage

`default_nettype wire

// ----- rtl/circular_list_cursor_engine.sv -----
`default_nettype none

// channel   direction  handshake                 payload
// in        to block   i_in_valid / o_in_ready   i_mode, i_insert_value, i_step_count
// out       from block o_out_valid / i_out_ready o_value_out, o_cursor_position,
//                                                o_node_count, o_ring_empty, o_status
//
// One word at a time. Insert scans the free map for the lowest free slot, one slot a
// cycle, then writes the node and links it in after the cursor (on an empty ring it
// links to itself); pop reads the cursor node and unlinks it; shift and seek wait on
// the bit-serial remainder unit for k, then follow k next links, one node a cycle on
// the next-link memory port (k < node count). Insert on a full ring and any other
// word on an empty ring skip the node work and go on to the result.
// After reset a clearing pass marks every slot free; no word
// is taken meanwhile. A waiting result is held in the output register while the
// next word is accepted; the block only stalls on a second result.
module circular_list_cursor_engine #(
    parameter int CAPACITY    = clce_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = clce_pkg::VALUE_WIDTH_DEF
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_in_valid,
    output logic                                      o_in_ready,
    input  wire  [1:0]                                i_mode,
    input  wire  signed [clce_pkg::VALUE_OUT_W-1:0]   i_insert_value,
    input  wire  [clce_pkg::STEP_W-1:0]               i_step_count,
    output logic                                      o_out_valid,
    input  wire                                       i_out_ready,
    output logic signed [clce_pkg::VALUE_OUT_W-1:0]   o_value_out,
    output logic [clce_pkg::POS_W-1:0]                o_cursor_position,
    output logic [clce_pkg::COUNT_OUT_W-1:0]          o_node_count,
    output logic                                      o_ring_empty,
    output logic [1:0]                                o_status
);
    import clce_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = SW + 1;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_SCAN  = 12'b0000_0000_0100,
        S_INS1  = 12'b0000_0000_1000,
        S_INS2  = 12'b0000_0001_0000,
        S_INS3  = 12'b0000_0010_0000,
        S_POPRD = 12'b0000_0100_0000,
        S_POP1  = 12'b0000_1000_0000,
        S_DIV   = 12'b0001_0000_0000,
        S_WALK  = 12'b0010_0000_0000,
        S_VRD   = 12'b0100_0000_0000,
        S_FIN   = 12'b1000_0000_0000
    } t_state;

    // node store
    logic [VALUE_WIDTH-1:0] r_value_mem [CAPACITY];
    logic [SW-1:0]          r_next_mem  [CAPACITY];
    logic [SW-1:0]          r_prev_mem  [CAPACITY];
    logic                   r_free_mem  [CAPACITY];

    logic [VALUE_WIDTH-1:0] r_val_q;
    logic [SW-1:0]          r_next_q;
    logic [SW-1:0]          r_prev_q;
    logic                   r_free_q;

    logic                   val_we, next_we, prev_we, free_we;
    logic [SW-1:0]          val_wa, next_wa, prev_wa, free_wa;
    logic [VALUE_WIDTH-1:0] val_wd;
    logic [SW-1:0]          next_wd, prev_wd;
    logic                   free_wd;
    logic [SW-1:0]          val_ra, next_ra, prev_ra, free_ra;

    // sequencer state
    t_state                 r_state, n_state;
    t_mode                  r_mode, n_mode;
    t_status                r_status, n_status;
    logic [VALUE_WIDTH-1:0] r_ival, n_ival;
    logic [SW-1:0]          r_head, n_head;
    logic [SW-1:0]          r_cur, n_cur;
    logic [SW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_count, n_count;
    logic [SW-1:0]          r_slot, n_slot;
    logic [SW-1:0]          r_scan_addr, n_scan_addr;
    logic                   r_scan_pend, n_scan_pend;
    logic [SW-1:0]          r_clr_addr, n_clr_addr;
    logic [SW-1:0]          r_walk_cnt, n_walk_cnt;
    logic [SW-1:0]          r_walk_slot, n_walk_slot;
    logic                   r_walk_first, n_walk_first;
    logic [VALUE_WIDTH-1:0] r_res_val, n_res_val;
    logic                   r_use_q, n_use_q;

    logic                   r_out_valid, n_out_valid;
    logic [VALUE_OUT_W-1:0] r_out_value, n_out_value;
    logic [POS_W-1:0]       r_out_pos, n_out_pos;
    logic [COUNT_OUT_W-1:0] r_out_count, n_out_count;
    logic                   r_out_empty, n_out_empty;
    logic [1:0]             r_out_status, n_out_status;

    // remainder unit
    logic                   rem_start;
    t_rem_status            rem_stat;
    logic [CW-1:0]          rem;

    logic [SW-1:0]          walk_pos;
    logic [SW-1:0]          k;
    logic [IW-1:0]          idx_sum;
    logic [VALUE_WIDTH-1:0] fin_val;

    clce_rem_unit #(
        .DIVIDEND_W (STEP_W),
        .DIVISOR_W  (CW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (i_step_count),
        .i_divisor  (r_count),
        .o_stat     (rem_stat),
        .o_rem      (rem)
    );

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_value_mem[val_wa] <= val_wd;
        end
        r_val_q <= r_value_mem[val_ra];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        r_next_q <= r_next_mem[next_ra];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        r_prev_q <= r_prev_mem[prev_ra];
    end

    always_ff @(posedge i_clk) begin
        if (free_we) begin
            r_free_mem[free_wa] <= free_wd;
        end
        r_free_q <= r_free_mem[free_ra];
    end

    assign k        = SW'(rem);
    assign walk_pos = r_walk_first ? r_walk_slot : r_next_q;
    assign idx_sum  = IW'(r_idx) + IW'(k);
    assign fin_val  = r_use_q ? r_val_q : r_res_val;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_status     = r_status;
        n_ival       = r_ival;
        n_head       = r_head;
        n_cur        = r_cur;
        n_idx        = r_idx;
        n_count      = r_count;
        n_slot       = r_slot;
        n_scan_addr  = r_scan_addr;
        n_scan_pend  = r_scan_pend;
        n_clr_addr   = r_clr_addr;
        n_walk_cnt   = r_walk_cnt;
        n_walk_slot  = r_walk_slot;
        n_walk_first = r_walk_first;
        n_res_val    = r_res_val;
        n_use_q      = r_use_q;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;
        n_out_empty  = r_out_empty;
        n_out_status = r_out_status;

        val_we  = 1'b0;
        val_wa  = r_slot;
        val_wd  = r_ival;
        next_we = 1'b0;
        next_wa = r_slot;
        next_wd = r_next_q;
        prev_we = 1'b0;
        prev_wa = r_slot;
        prev_wd = r_cur;
        free_we = 1'b0;
        free_wa = r_slot;
        free_wd = 1'b0;
        val_ra  = r_cur;
        next_ra = r_cur;
        prev_ra = r_cur;
        free_ra = r_scan_addr;

        rem_start  = 1'b0;
        o_in_ready = (r_state == S_IDLE);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                free_we    = 1'b1;
                free_wa    = r_clr_addr;
                free_wd    = 1'b1;
                n_clr_addr = r_clr_addr + SW'(1);
                if (r_clr_addr == SW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode      = t_mode'(i_mode);
                    n_ival      = VALUE_WIDTH'($unsigned(i_insert_value));
                    n_status    = ST_OK;
                    n_use_q     = 1'b0;
                    n_res_val   = '0;
                    n_scan_addr = '0;
                    n_scan_pend = 1'b0;
                    if (t_mode'(i_mode) == MODE_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_VRD;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_FIN;
                    end else if (t_mode'(i_mode) == MODE_POP) begin
                        n_state = S_POPRD;
                    end else begin
                        rem_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end

            S_SCAN: begin
                // reads run one slot ahead of the check
                if (r_scan_pend && r_free_q) begin
                    n_state = S_INS1;
                end else begin
                    n_slot      = r_scan_addr;
                    n_scan_pend = 1'b1;
                    n_scan_addr = (r_scan_addr == SW'(CAPACITY - 1)) ? '0
                                                                    : r_scan_addr + SW'(1);
                end
            end

            S_INS1: begin
                val_we    = 1'b1;
                free_we   = 1'b1;
                n_res_val = r_ival;
                if (r_count == '0) begin
                    next_we = 1'b1;
                    next_wd = r_slot;
                    prev_we = 1'b1;
                    prev_wd = r_slot;
                    n_head  = r_slot;
                    n_cur   = r_slot;
                    n_idx   = '0;
                    n_count = CW'(1);
                    n_state = S_FIN;
                end else begin
                    prev_we = 1'b1;
                    n_state = S_INS2;
                end
            end

            S_INS2: begin
                // r_next_q holds the old successor of the cursor
                next_we = 1'b1;
                prev_we = 1'b1;
                prev_wa = r_next_q;
                prev_wd = r_slot;
                n_state = S_INS3;
            end

            S_INS3: begin
                next_we = 1'b1;
                next_wa = r_cur;
                next_wd = r_slot;
                n_cur   = r_slot;
                n_idx   = r_idx + SW'(1);
                n_count = r_count + CW'(1);
                n_state = S_FIN;
            end

            S_POPRD: begin
                n_state = S_POP1;
            end

            S_POP1: begin
                free_we   = 1'b1;
                free_wa   = r_cur;
                free_wd   = 1'b1;
                n_res_val = r_val_q;
                n_count   = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_head = '0;
                    n_cur  = '0;
                    n_idx  = '0;
                end else begin
                    // unlink: join predecessor and successor
                    next_we = 1'b1;
                    next_wa = r_prev_q;
                    next_wd = r_next_q;
                    prev_we = 1'b1;
                    prev_wa = r_next_q;
                    prev_wd = r_prev_q;
                    n_cur   = r_next_q;
                    if (r_cur == r_head) begin
                        n_head = r_next_q;
                        n_idx  = '0;
                    end else if (IW'(r_idx) + IW'(1) == IW'(r_count)) begin
                        n_idx = '0;
                    end
                end
                n_state = S_FIN;
            end

            S_DIV: begin
                if (rem_stat.done) begin
                    n_walk_cnt   = k;
                    n_walk_first = 1'b1;
                    if (r_mode == MODE_SEEK) begin
                        n_walk_slot = r_head;
                        n_idx       = k;
                    end else begin
                        n_walk_slot = r_cur;
                        n_idx       = (idx_sum >= IW'(r_count)) ? SW'(idx_sum - IW'(r_count))
                                                               : SW'(idx_sum);
                    end
                    n_state = S_WALK;
                end
            end

            S_WALK: begin
                // follow one next link a cycle
                next_ra = walk_pos;
                if (r_walk_cnt == '0) begin
                    n_cur   = walk_pos;
                    n_state = S_VRD;
                end else begin
                    n_walk_cnt   = r_walk_cnt - SW'(1);
                    n_walk_first = 1'b0;
                end
            end

            S_VRD: begin
                n_use_q = 1'b1;
                n_state = S_FIN;
            end

            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = VALUE_OUT_W'(fin_val);
                    n_out_pos    = (r_count == '0) ? '0 : POS_W'(r_idx);
                    n_out_count  = COUNT_OUT_W'(r_count);
                    n_out_empty  = (r_count == '0);
                    n_out_status = r_status;
                    if (r_mode != MODE_POP && r_count == '0) begin
                        n_out_value = '0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_head      <= '0;
            r_cur       <= '0;
            r_idx       <= '0;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_scan_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_cur       <= n_cur;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_clr_addr  <= n_clr_addr;
            r_scan_pend <= n_scan_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_status     <= n_status;
        r_ival       <= n_ival;
        r_slot       <= n_slot;
        r_scan_addr  <= n_scan_addr;
        r_walk_cnt   <= n_walk_cnt;
        r_walk_slot  <= n_walk_slot;
        r_walk_first <= n_walk_first;
        r_res_val    <= n_res_val;
        r_use_q      <= n_use_q;
        r_out_value  <= n_out_value;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
        r_out_empty  <= n_out_empty;
        r_out_status <= n_out_status;
    end

    assign o_out_valid       = r_out_valid;
    assign o_value_out       = $signed(r_out_value);
    assign o_cursor_position = r_out_pos;
    assign o_node_count      = r_out_count;
    assign o_ring_empty      = r_out_empty;
    assign o_status          = r_out_status;

endmodule

`default_nettype wire

// ----- rtl/clce_rem_unit.sv -----
`default_nettype none

module clce_rem_unit #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 7
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [DIVIDEND_W-1:0]      i_dividend,
    input  wire  [DIVISOR_W-1:0]       i_divisor,
    output clce_pkg::t_rem_status      o_stat,
    output logic [DIVISOR_W-1:0]       o_rem
);
    import clce_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [DIVISOR_W-1:0]  r_dsr;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W-1:0]  n_rem;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[DIVIDEND_W-1]};
        if (trial >= {1'b0, r_dsr}) begin
            n_rem = DIVISOR_W'(trial - {1'b0, r_dsr});
        end else begin
            n_rem = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DIVIDEND_W-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

`default_nettype wire
